### src/hmf_pkg.sv
// Shared types and constants for the height grid rectangle max-fill block.
`timescale 1ns / 1ps
`default_nettype none
package hmf_pkg;

  localparam int COL_W    = 6;
  localparam int ROW_W    = 6;
  localparam int DIM_W    = 7;
  localparam int HEIGHT_W = 15;
  localparam int IN_H_W   = 16;
  localparam int ADDR_W   = COL_W + ROW_W;
  localparam int CELLS    = 1 << ADDR_W;
  localparam int STATUS_W = 2;

  localparam int REG_ADDR_W = 3;
  localparam int DATA_W     = 32;

  localparam logic [DIM_W-1:0] MAX_WIDTH  = DIM_W'(64);
  localparam logic [DIM_W-1:0] MAX_DEPTH  = DIM_W'(64);
  localparam logic [DIM_W-1:0] GRID_RESET = DIM_W'(10);

  localparam logic REG_GRID_WIDTH = 1'b0;
  localparam logic REG_GRID_DEPTH = 1'b1;

  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_READ   = 2'd2;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = 1;
  localparam int FIFO_CNT_W = 2;

  typedef enum logic [1:0] {
    CMD_REJECT,
    CMD_DONE,
    CMD_READ,
    CMD_ADD
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [COL_W-1:0]      x;
    logic [ROW_W-1:0]      z;
    logic [COL_W-1:0]      x_last;
    logic [ROW_W-1:0]      z_last;
    logic [HEIGHT_W-1:0]   height;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_RD_WAIT,
    BK_WALK,
    BK_DRAIN
  } back_state_t;

endpackage
`default_nettype wire

### src/hmf_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module hmf_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 256,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [AW-1:0]     raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### src/hmf_front.sv
// Front end: accepts items, checks bounds and turns each into a command.
`timescale 1ns / 1ps
`default_nettype none
module hmf_front (
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         in_func,
  input  wire logic [hmf_pkg::COL_W-1:0]    in_x,
  input  wire logic [hmf_pkg::ROW_W-1:0]    in_z,
  input  wire logic [hmf_pkg::DIM_W-1:0]    in_x_size,
  input  wire logic [hmf_pkg::DIM_W-1:0]    in_z_size,
  input  wire logic signed [hmf_pkg::IN_H_W-1:0] in_height,
  input  wire logic [hmf_pkg::DIM_W-1:0]    grid_width,
  input  wire logic [hmf_pkg::DIM_W-1:0]    grid_depth,
  input  wire hmf_pkg::fifo_stat_t          fifo_stat,
  input  wire logic                         clearing,
  output logic                              push,
  output hmf_pkg::cmd_t                     cmd
);
  import hmf_pkg::*;

  logic [DIM_W-1:0] eff_w;
  logic [DIM_W-1:0] eff_d;
  logic [DIM_W:0]   x_end;
  logic [DIM_W:0]   z_end;
  logic             add_ok;
  logic             read_ok;
  logic             empty_rect;

  always_comb begin
    eff_w      = (grid_width > MAX_WIDTH) ? MAX_WIDTH : grid_width;
    eff_d      = (grid_depth > MAX_DEPTH) ? MAX_DEPTH : grid_depth;
    x_end      = {2'b00, in_x} + {1'b0, in_x_size};
    z_end      = {2'b00, in_z} + {1'b0, in_z_size};
    add_ok     = !in_height[IN_H_W-1] && (x_end <= {1'b0, eff_w})
                 && (z_end <= {1'b0, eff_d});
    read_ok    = ({1'b0, in_x} < eff_w) && ({1'b0, in_z} < eff_d);
    empty_rect = (in_x_size == '0) || (in_z_size == '0);

    busy = fifo_stat.full || clearing;
    push = start && !busy;

    cmd.x      = in_x;
    cmd.z      = in_z;
    // Last covered column/row; only meaningful for a non-empty add in bounds.
    cmd.x_last = COL_W'(x_end - 1'b1);
    cmd.z_last = ROW_W'(z_end - 1'b1);
    cmd.height = in_height[HEIGHT_W-1:0];

    unique case (in_func)
      FUNC_READ: cmd.kind = read_ok ? CMD_READ : CMD_REJECT;
      default: begin
        if (!add_ok) begin
          cmd.kind = CMD_REJECT;
        end else if (empty_rect) begin
          cmd.kind = CMD_DONE;
        end else begin
          cmd.kind = CMD_ADD;
        end
      end
    endcase
  end

endmodule
`default_nettype wire

### src/hmf_fifo.sv
// Two-entry command queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module hmf_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire hmf_pkg::cmd_t        push_cmd,
  input  wire logic                 pop,
  output hmf_pkg::cmd_t             head,
  output hmf_pkg::fifo_stat_t       stat
);
  import hmf_pkg::*;

  cmd_t                  slot_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r;
  logic [FIFO_CNT_W-1:0] count_nxt;
  logic                  do_push;
  logic                  do_pop;

  always_comb begin
    stat.full  = (count_r == FIFO_CNT_W'(FIFO_DEPTH));
    stat.empty = (count_r == '0);
    do_push    = push && !stat.full;
    do_pop     = pop && !stat.empty;
    head       = slot_r[rd_ptr_r];
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + FIFO_CNT_W'(do_push) - FIFO_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

### src/hmf_back.sv
// Back end: clears the grid after reset and executes queued commands.
`timescale 1ns / 1ps
`default_nettype none
module hmf_back (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire hmf_pkg::fifo_stat_t            fifo_stat,
  input  wire hmf_pkg::cmd_t                  head,
  output logic                                pop,
  output logic                                clearing,
  output logic                                out_valid,
  output logic [hmf_pkg::STATUS_W-1:0]        out_status,
  output logic [hmf_pkg::HEIGHT_W-1:0]        out_cell_height
);
  import hmf_pkg::*;

  back_state_t         state_r;
  back_state_t         state_nxt;
  cmd_t                cur_r;
  cmd_t                cur_nxt;
  logic [COL_W-1:0]    col_r;
  logic [COL_W-1:0]    col_nxt;
  logic [ROW_W-1:0]    row_r;
  logic [ROW_W-1:0]    row_nxt;
  logic                p_valid_r;
  logic                p_valid_nxt;
  logic [ADDR_W-1:0]   p_addr_r;
  logic [ADDR_W-1:0]   p_addr_nxt;
  logic [ADDR_W-1:0]   clr_addr_r;
  logic [ADDR_W-1:0]   clr_addr_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [STATUS_W-1:0] out_status_nxt;
  logic [HEIGHT_W-1:0] out_height_r;
  logic [HEIGHT_W-1:0] out_height_nxt;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [HEIGHT_W-1:0] ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [HEIGHT_W-1:0] ram_rdata;

  hmf_ram #(
    .DATA_W (HEIGHT_W),
    .DEPTH  (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_addr_r  <= '0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    col_r        <= col_nxt;
    row_r        <= row_nxt;
    p_addr_r     <= p_addr_nxt;
    out_status_r <= out_status_nxt;
    out_height_r <= out_height_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    p_valid_nxt    = 1'b0;
    p_addr_nxt     = p_addr_r;
    clr_addr_nxt   = clr_addr_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_height_nxt = '0;
    pop            = 1'b0;
    ram_raddr      = {row_r, col_r};
    // Write-back stage of the read-modify-write walk.
    ram_we         = p_valid_r && (ram_rdata < cur_r.height);
    ram_waddr      = p_addr_r;
    ram_wdata      = cur_r.height;

    unique case (state_r)
      BK_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == '1) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (!fifo_stat.empty) begin
          pop     = 1'b1;
          cur_nxt = head;
          unique case (head.kind)
            CMD_REJECT: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_REJECT;
            end
            CMD_DONE: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_DONE;
            end
            CMD_READ: begin
              ram_raddr = {head.z, head.x};
              state_nxt = BK_RD_WAIT;
            end
            CMD_ADD: begin
              col_nxt   = head.x;
              row_nxt   = head.z;
              state_nxt = BK_WALK;
            end
            default: state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_RD_WAIT: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_READ;
        out_height_nxt = ram_rdata;
        state_nxt      = BK_IDLE;
      end
      BK_WALK: begin
        p_valid_nxt = 1'b1;
        p_addr_nxt  = {row_r, col_r};
        if (col_r == cur_r.x_last) begin
          col_nxt = cur_r.x;
          if (row_r == cur_r.z_last) begin
            state_nxt = BK_DRAIN;
          end else begin
            row_nxt = row_r + 1'b1;
          end
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      BK_DRAIN: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_DONE;
        state_nxt      = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  assign clearing        = (state_r == BK_CLEAR);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_cell_height = out_height_r;

endmodule
`default_nettype wire

### src/heightmap_rectangle_max_fill.sv
// Top level of the height grid rectangle max-fill block.
//
//  channel  | handshake                      | beat
//  ---------+--------------------------------+---------------------------------------
//  input    | start && !busy                 | in_func, in_x, in_z, in_x_size,
//           |                                | in_z_size, in_height
//  result   | out_valid, one cycle           | out_status, out_cell_height
//  config   | psel & penable & pwrite        | paddr, pwdata (prdata on reads)
//
// A read waits in BK_RD_WAIT for the registered RAM read port; rejects and empty adds answer straight from BK_IDLE.
// An add walks every covered cell through a pipelined read-modify-write on
// the grid RAM, then signals done from BK_DRAIN.
// After reset a clearing pass zeroes the RAM, one cell per cycle, while busy
// is high; config writes are taken throughout.
// A two-entry command queue lets up to two more items be accepted while
// the back end works. The receiver cannot stall results.
`timescale 1ns / 1ps
`default_nettype none
module heightmap_rectangle_max_fill (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              in_func,
  input  wire logic [hmf_pkg::COL_W-1:0]         in_x,
  input  wire logic [hmf_pkg::ROW_W-1:0]         in_z,
  input  wire logic [hmf_pkg::DIM_W-1:0]         in_x_size,
  input  wire logic [hmf_pkg::DIM_W-1:0]         in_z_size,
  input  wire logic signed [hmf_pkg::IN_H_W-1:0] in_height,
  output logic                                   out_valid,
  output logic [hmf_pkg::STATUS_W-1:0]           out_status,
  output logic [hmf_pkg::HEIGHT_W-1:0]           out_cell_height,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [hmf_pkg::REG_ADDR_W-1:0]    paddr,
  input  wire logic [hmf_pkg::DATA_W-1:0]        pwdata,
  output logic [hmf_pkg::DATA_W-1:0]             prdata,
  output logic                                   pready
);
  import hmf_pkg::*;

  logic [DIM_W-1:0] grid_width_r;
  logic [DIM_W-1:0] grid_width_nxt;
  logic [DIM_W-1:0] grid_depth_r;
  logic [DIM_W-1:0] grid_depth_nxt;
  logic             cfg_wr;
  logic             reg_sel;

  fifo_stat_t fifo_stat;
  cmd_t       push_cmd;
  cmd_t       head;
  logic       push;
  logic       pop;
  logic       clearing;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    grid_width_nxt = grid_width_r;
    grid_depth_nxt = grid_depth_r;
    if (cfg_wr) begin
      unique case (reg_sel)
        REG_GRID_WIDTH: grid_width_nxt = pwdata[DIM_W-1:0];
        REG_GRID_DEPTH: grid_depth_nxt = pwdata[DIM_W-1:0];
        default: grid_width_nxt = grid_width_r;
      endcase
    end
    unique case (reg_sel)
      REG_GRID_WIDTH: prdata = DATA_W'(grid_width_r);
      REG_GRID_DEPTH: prdata = DATA_W'(grid_depth_r);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r <= GRID_RESET;
      grid_depth_r <= GRID_RESET;
    end else begin
      grid_width_r <= grid_width_nxt;
      grid_depth_r <= grid_depth_nxt;
    end
  end

  hmf_front u_front (
    .start      (start),
    .busy       (busy),
    .in_func    (in_func),
    .in_x       (in_x),
    .in_z       (in_z),
    .in_x_size  (in_x_size),
    .in_z_size  (in_z_size),
    .in_height  (in_height),
    .grid_width (grid_width_r),
    .grid_depth (grid_depth_r),
    .fifo_stat  (fifo_stat),
    .clearing   (clearing),
    .push       (push),
    .cmd        (push_cmd)
  );

  hmf_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (fifo_stat)
  );

  hmf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .fifo_stat       (fifo_stat),
    .head            (head),
    .pop             (pop),
    .clearing        (clearing),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_cell_height (out_cell_height)
  );

  a_clear_busy: assert property (@(posedge clk) clearing |-> busy)
    else $error("item could be accepted during the clearing pass");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clearing) |-> !out_valid)
    else $error("result beat right after the clearing pass");

  a_height_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_READ) |-> out_cell_height == '0)
    else $error("nonzero height on a non-read result");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_DONE || out_status == ST_REJECT
                   || out_status == ST_READ))
    else $error("undefined status code on a result beat");

endmodule
`default_nettype wire
